// ===== hw/rtl/pnsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pnsd_pkg
// shared constants, command and status types for the polyline distance block
// ----------------------------------------------------------------------------
package pnsd_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int PT_AW        = $clog2(MAX_SEGMENTS + 1);
    localparam int SEG_W        = $clog2(MAX_SEGMENTS);
    localparam int CW           = 24;
    localparam int DW           = CW + 1;
    localparam int EW           = CW + 2;
    localparam int LEN_W        = 2 * DW;
    localparam int DOT_W        = LEN_W + 1;
    localparam int REM_W        = DOT_W;
    localparam int SQ_W         = 50;
    localparam int ROOT_W       = SQ_W / 2;
    localparam int SL_W         = 22;
    localparam int SIU_W        = 7;
    localparam int BEST_W       = SL_W + 2;
    localparam int Q_W          = 16;
    localparam int DIV_STEPS    = Q_W;
    localparam int DIV_CW       = $clog2(DIV_STEPS);
    localparam int DIST_W       = 25;
    localparam int TAG_W        = 8;

    typedef enum logic [1:0] {
        RD_START,
        RD_END,
        RD_BEST
    } t_rd_sel;

    typedef struct packed {
        logic    wr_point;
        logic    ld_query;
        logic    bsq;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    lat_start;
        logic    lat_end;
        logic    diff;
        logic    mul_a;
        logic    mul_b;
        logic    dec;
        logic    div_step;
        logic    proj;
        logic    sq;
        logic    sqrt_start;
        logic    take_win;
        logic    next_seg;
        logic    rest_diff;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic last_seg;
        logic triv;
        logic win;
        logic sqrt_done;
        logic out_busy;
    } t_sts;

endpackage

// ===== hw/rtl/polyline_nearest_segment_distance.sv =====
// ----------------------------------------------------------------------------
// polyline_nearest_segment_distance
// nearest polyline segment and distances for a queried position
//
// channel   direction  contents
// s_axis    in         tuser: mode; tdata: point_index, pos_x, pos_y, insect_tag
// m_axis    out        tdata: result_tag, nearest_segment, nearest_distance,
//                      lost, resting_distance
// apb       in/out     sensor reach at 0x0, segments_in_use at 0x4
//
// a load writes one point; a query walks the segments, each through a clamped
// projection or the serial divider, runs the shared square root for each new
// minimum, then uses it again for the start-point distance
// one request in flight; the next is taken while a result waits on m_axis
// synchronous active-low reset; the point store is not cleared
// ----------------------------------------------------------------------------
module polyline_nearest_segment_distance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // point_index, pos_x, pos_y, insect_tag
    input  logic        i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // result_tag, nearest_segment,
                                          // nearest_distance, lost, resting_distance
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = pnsd_pkg::PT_AW;
    localparam int CW = pnsd_pkg::CW;

    logic [pnsd_pkg::SL_W-1:0]   r_reach;
    logic [pnsd_pkg::SIU_W-1:0]  r_segments_in_use;
    pnsd_pkg::t_cmd              cmd;
    pnsd_pkg::t_sts              sts;
    logic                        in_valid;

    logic [pnsd_pkg::TAG_W-1:0]  result_tag;
    logic [pnsd_pkg::SEG_W-1:0]  nearest_segment;
    logic [pnsd_pkg::DIST_W-1:0] nearest_distance;
    logic                        lost;
    logic [pnsd_pkg::DIST_W-1:0] resting_distance;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach           <= pnsd_pkg::SL_W'(2560);
            r_segments_in_use <= pnsd_pkg::SIU_W'(64);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_segments_in_use <= pwdata[pnsd_pkg::SIU_W-1:0];
            end else begin
                r_reach <= pwdata[pnsd_pkg::SL_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? 32'(r_segments_in_use) : 32'(r_reach);

    assign in_valid = i_s_axis_tvalid;

    pnsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_mode     (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pnsd_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_point_index      (i_s_axis_tdata[AW-1:0]),
        .i_pos_x            (i_s_axis_tdata[AW+CW-1:AW]),
        .i_pos_y            (i_s_axis_tdata[AW+2*CW-1:AW+CW]),
        .i_insect_tag       (i_s_axis_tdata[AW+2*CW+7:AW+2*CW]),
        .i_reach            (r_reach),
        .i_segments_in_use  (r_segments_in_use),
        .i_out_ready        (i_m_axis_tready),
        .o_out_valid        (o_m_axis_tvalid),
        .o_result_tag       (result_tag),
        .o_nearest_segment  (nearest_segment),
        .o_nearest_distance (nearest_distance),
        .o_lost             (lost),
        .o_resting_distance (resting_distance)
    );

    assign o_m_axis_tdata = {7'b0, resting_distance, lost, nearest_distance,
                             nearest_segment, result_tag};

endmodule

// ===== hw/rtl/pnsd_sqrt.sv =====
// ----------------------------------------------------------------------------
// pnsd_sqrt
// integer square root rounded down, one result bit per cycle
// ----------------------------------------------------------------------------
module pnsd_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pnsd_pkg::SQ_W-1:0]  i_radicand,
    output logic                       o_done,
    output logic [pnsd_pkg::ROOT_W-1:0] o_root
);

    localparam int RW  = pnsd_pkg::ROOT_W + 2;
    localparam int CNW = $clog2(pnsd_pkg::ROOT_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNW-1:0]              r_cnt;
    logic [pnsd_pkg::SQ_W-1:0]   r_rad;
    logic [RW-1:0]               r_rem;
    logic [pnsd_pkg::ROOT_W-1:0] r_root;

    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;

    assign rem_sh = {r_rem, r_rad[pnsd_pkg::SQ_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNW'(pnsd_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[pnsd_pkg::SQ_W-3:0], 2'b00};
            if (ge) begin
                r_rem  <= RW'(rem_sh - trial);
                r_root <= {r_root[pnsd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= RW'(rem_sh);
                r_root <= {r_root[pnsd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/pnsd_datapath.sv =====
// ----------------------------------------------------------------------------
// pnsd_datapath
// point store, segment projection arithmetic, divider, minimum tracking
// ----------------------------------------------------------------------------
module pnsd_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pnsd_pkg::t_cmd                       i_cmd,
    output pnsd_pkg::t_sts                       o_sts,
    input  logic [pnsd_pkg::PT_AW-1:0]           i_point_index,
    input  logic signed [pnsd_pkg::CW-1:0]       i_pos_x,
    input  logic signed [pnsd_pkg::CW-1:0]       i_pos_y,
    input  logic [pnsd_pkg::TAG_W-1:0]           i_insect_tag,
    input  logic [pnsd_pkg::SL_W-1:0]            i_reach,
    input  logic [pnsd_pkg::SIU_W-1:0]           i_segments_in_use,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [pnsd_pkg::TAG_W-1:0]           o_result_tag,
    output logic [pnsd_pkg::SEG_W-1:0]           o_nearest_segment,
    output logic [pnsd_pkg::DIST_W-1:0]          o_nearest_distance,
    output logic                                 o_lost,
    output logic [pnsd_pkg::DIST_W-1:0]          o_resting_distance
);

    localparam int CW    = pnsd_pkg::CW;
    localparam int DW    = pnsd_pkg::DW;
    localparam int EW    = pnsd_pkg::EW;
    localparam int LEN_W = pnsd_pkg::LEN_W;
    localparam int DOT_W = pnsd_pkg::DOT_W;
    localparam int REM_W = pnsd_pkg::REM_W;
    localparam int SQ_W  = pnsd_pkg::SQ_W;
    localparam int Q_W   = pnsd_pkg::Q_W;
    localparam int PT_AW = pnsd_pkg::PT_AW;
    localparam int SEG_W = pnsd_pkg::SEG_W;
    localparam int BW    = pnsd_pkg::BEST_W;
    localparam int MQ_W  = Q_W + 1 + DW;
    localparam logic [pnsd_pkg::SIU_W-1:0] SIU_MAX = pnsd_pkg::SIU_W'(pnsd_pkg::MAX_SEGMENTS);

    logic [2*CW-1:0] mem [0:pnsd_pkg::MAX_SEGMENTS];
    logic [2*CW-1:0] r_rd_data;
    logic [PT_AW-1:0] rd_addr;

    logic signed [CW-1:0]    r_p0x, r_p0y, r_p1x, r_p1y, r_p2x, r_p2y;
    logic [pnsd_pkg::TAG_W-1:0] r_tag;
    logic [PT_AW-1:0]        r_n, r_j;
    logic [BW-1:0]           r_best;
    logic [2*BW-1:0]         r_bestsq;
    logic [SEG_W-1:0]        r_best_seg;
    logic signed [DW-1:0]    r_dx, r_dy, r_vx, r_vy;
    logic [LEN_W-1:0]        r_len2;
    logic signed [DOT_W-1:0] r_dot;
    logic [REM_W-1:0]        r_rem;
    logic [Q_W-1:0]          r_q;
    logic signed [EW-1:0]    r_ex, r_ey;
    logic [SQ_W-1:0]         r_s;
    logic                    r_out_valid;

    logic signed [LEN_W-1:0] m_xx, m_yy;
    logic signed [DOT_W-1:0] m_xv, m_yv;
    logic signed [MQ_W-1:0]  m_qx, m_qy;
    logic signed [2*EW-1:0]  m_ex, m_ey;
    logic [REM_W-1:0]        rem_sh;
    logic                    rem_ge;
    logic                    t_zero, t_one;
    logic                    sqrt_done;
    logic [pnsd_pkg::ROOT_W-1:0] root;
    logic [BW-1:0]           start_best;
    logic [PT_AW-1:0]        n_clip;

    assign m_xx   = r_dx * r_dx;
    assign m_yy   = r_dy * r_dy;
    assign m_xv   = r_dx * r_vx;
    assign m_yv   = r_dy * r_vy;
    assign m_qx   = $signed({1'b0, r_q}) * r_dx;
    assign m_qy   = $signed({1'b0, r_q}) * r_dy;
    assign m_ex   = r_ex * r_ex;
    assign m_ey   = r_ey * r_ey;
    assign rem_sh = {r_rem[REM_W-2:0], 1'b0};
    assign rem_ge = rem_sh >= {1'b0, r_len2};
    assign t_zero = (r_len2 == '0) || r_dot[DOT_W-1] || (r_dot == '0);
    assign t_one  = r_dot >= $signed({1'b0, r_len2});

    assign start_best = {2'b00, i_reach} + {1'b0, i_reach, 1'b0};
    assign n_clip = (i_segments_in_use > SIU_MAX) ? PT_AW'(pnsd_pkg::MAX_SEGMENTS)
                                                  : PT_AW'(i_segments_in_use);

    always_comb begin
        unique case (i_cmd.rd_sel)
            pnsd_pkg::RD_START: rd_addr = r_j;
            pnsd_pkg::RD_END:   rd_addr = r_j + 1'b1;
            pnsd_pkg::RD_BEST:  rd_addr = PT_AW'(r_best_seg);
            default:            rd_addr = r_j;
        endcase
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_point && (i_point_index <= PT_AW'(pnsd_pkg::MAX_SEGMENTS))) begin
            mem[i_point_index] <= {i_pos_y, i_pos_x};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    pnsd_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (r_s),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_query) begin
            r_p0x      <= i_pos_x;
            r_p0y      <= i_pos_y;
            r_tag      <= i_insect_tag;
            r_j        <= '0;
            r_n        <= n_clip;
            r_best     <= start_best;
            r_best_seg <= '0;
        end
        if (i_cmd.bsq) begin
            r_bestsq <= r_best * r_best;
        end
        if (i_cmd.lat_start) begin
            r_p1x <= r_rd_data[CW-1:0];
            r_p1y <= r_rd_data[2*CW-1:CW];
        end
        if (i_cmd.lat_end) begin
            r_p2x <= r_rd_data[CW-1:0];
            r_p2y <= r_rd_data[2*CW-1:CW];
        end
        if (i_cmd.next_seg) begin
            r_p1x <= r_p2x;
            r_p1y <= r_p2y;
            r_j   <= r_j + 1'b1;
        end
        if (i_cmd.diff) begin
            r_dx <= DW'(r_p1x) - DW'(r_p2x);
            r_dy <= DW'(r_p1y) - DW'(r_p2y);
            r_vx <= DW'(r_p0x) - DW'(r_p2x);
            r_vy <= DW'(r_p0y) - DW'(r_p2y);
        end
        if (i_cmd.mul_a) begin
            r_len2 <= $unsigned(m_xx);
            r_dot  <= m_xv;
        end
        if (i_cmd.mul_b) begin
            r_len2 <= r_len2 + $unsigned(m_yy);
            r_dot  <= r_dot + m_yv;
        end
        if (i_cmd.dec) begin
            if (t_zero) begin
                r_ex <= EW'(r_vx);
                r_ey <= EW'(r_vy);
            end else if (t_one) begin
                r_ex <= EW'(r_vx) - EW'(r_dx);
                r_ey <= EW'(r_vy) - EW'(r_dy);
            end
            r_rem <= $unsigned(r_dot);
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= rem_sh - {1'b0, r_len2};
                r_q   <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[Q_W-2:0], 1'b0};
            end
        end
        if (i_cmd.proj) begin
            r_ex <= EW'(r_vx) - $signed(m_qx[MQ_W-1:Q_W]);
            r_ey <= EW'(r_vy) - $signed(m_qy[MQ_W-1:Q_W]);
        end
        if (i_cmd.rest_diff) begin
            r_ex <= EW'(r_p1x) - EW'(r_p0x);
            r_ey <= EW'(r_p1y) - EW'(r_p0y);
        end
        if (i_cmd.sq) begin
            r_s <= m_ex[SQ_W-1:0] + m_ey[SQ_W-1:0];
        end
        if (i_cmd.take_win) begin
            r_best     <= root[BW-1:0];
            r_best_seg <= r_j[SEG_W-1:0];
        end
        if (i_cmd.out_load) begin
            o_result_tag       <= r_tag;
            o_nearest_segment  <= r_best_seg;
            o_nearest_distance <= pnsd_pkg::DIST_W'(r_best);
            o_lost             <= r_best >= {1'b0, i_reach, 1'b0};
            o_resting_distance <= pnsd_pkg::DIST_W'(root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sts.n_zero     = (r_n == '0);
    assign o_sts.last_seg   = ((r_j + 1'b1) == r_n);
    assign o_sts.triv       = t_zero || t_one;
    assign o_sts.win        = r_s < {{(SQ_W-2*BW){1'b0}}, r_bestsq};
    assign o_sts.sqrt_done  = sqrt_done;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

endmodule

// ===== hw/rtl/pnsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pnsd_ctrl
// sequencer for loads, the segment walk and the start-point distance
// ----------------------------------------------------------------------------
module pnsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_mode,
    output logic           o_in_ready,
    input  pnsd_pkg::t_sts i_sts,
    output pnsd_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_BSQ, S_LSTART, S_LEND, S_DIFF, S_MULA, S_MULB, S_DEC, S_DIV,
        S_PROJ, S_SQ, S_CMP, S_SQRT, S_WIN, S_WBSQ, S_NXT, S_RDE,
        S_RLAT, S_RDIFF, S_RSQ, S_RGO, S_RWAIT, S_OUT
    } t_state;

    t_state                      r_state, n_state;
    logic [pnsd_pkg::DIV_CW-1:0] r_cnt, n_cnt;
    pnsd_pkg::t_cmd              cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode) begin
                        cmd.ld_query = 1'b1;
                        n_state      = S_BSQ;
                    end else begin
                        cmd.wr_point = 1'b1;
                    end
                end
            end
            S_BSQ: begin
                cmd.bsq   = 1'b1;
                cmd.rd_en = 1'b1;
                if (i_sts.n_zero) begin
                    cmd.rd_sel = pnsd_pkg::RD_BEST;
                    n_state    = S_RLAT;
                end else begin
                    cmd.rd_sel = pnsd_pkg::RD_START;
                    n_state    = S_LSTART;
                end
            end
            S_LSTART: begin
                cmd.lat_start = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = pnsd_pkg::RD_END;
                n_state       = S_LEND;
            end
            S_LEND: begin
                cmd.lat_end = 1'b1;
                n_state     = S_DIFF;
            end
            S_DIFF: begin
                cmd.diff = 1'b1;
                n_state  = S_MULA;
            end
            S_MULA: begin
                cmd.mul_a = 1'b1;
                n_state   = S_MULB;
            end
            S_MULB: begin
                cmd.mul_b = 1'b1;
                n_state   = S_DEC;
            end
            S_DEC: begin
                cmd.dec = 1'b1;
                n_cnt   = '0;
                n_state = i_sts.triv ? S_SQ : S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == pnsd_pkg::DIV_CW'(pnsd_pkg::DIV_STEPS - 1)) begin
                    n_state = S_PROJ;
                end
            end
            S_PROJ: begin
                cmd.proj = 1'b1;
                n_state  = S_SQ;
            end
            S_SQ: begin
                cmd.sq  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.win) begin
                    cmd.sqrt_start = 1'b1;
                    n_state        = S_SQRT;
                end else begin
                    n_state = S_NXT;
                end
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                cmd.take_win = 1'b1;
                n_state      = S_WBSQ;
            end
            S_WBSQ: begin
                cmd.bsq = 1'b1;
                n_state = S_NXT;
            end
            S_NXT: begin
                if (i_sts.last_seg) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = pnsd_pkg::RD_BEST;
                    n_state    = S_RLAT;
                end else begin
                    cmd.next_seg = 1'b1;
                    n_state      = S_RDE;
                end
            end
            S_RDE: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = pnsd_pkg::RD_END;
                n_state    = S_LEND;
            end
            S_RLAT: begin
                cmd.lat_start = 1'b1;
                n_state       = S_RDIFF;
            end
            S_RDIFF: begin
                cmd.rest_diff = 1'b1;
                n_state       = S_RSQ;
            end
            S_RSQ: begin
                cmd.sq  = 1'b1;
                n_state = S_RGO;
            end
            S_RGO: begin
                cmd.sqrt_start = 1'b1;
                n_state        = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

`ifndef SYNTH
    a_sqrt_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sqrt_start |=> !i_sts.sqrt_done)
        else $error("square root finished one cycle after start");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !i_sts.out_busy)
        else $error("result loaded over a waiting result");

    a_latch_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.lat_start, cmd.lat_end, cmd.next_seg}))
        else $error("conflicting point register updates");

    a_win_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) && i_sts.win |=> (r_state == S_SQRT))
        else $error("winning segment did not start square root");
`endif

endmodule
